FILE: rtl/core/fppr_pkg.sv
package fppr_pkg;

	typedef logic [5:0] field_id_t;
	typedef logic [8:0] part_count_t;
	typedef logic [36:0] field_vec_t;

	localparam int NumFields = 37;

	localparam part_count_t MAX_PARTS = 9'd256;

	localparam field_id_t FIELD_INDEX        = 6'd0;
	localparam field_id_t FIELD_FLAGS        = 6'd1;
	localparam field_id_t FIELD_VERTEX_FLAGS = 6'd22;
	localparam field_id_t FIELD_BLEND_FLAGS  = 6'd28;
	localparam field_id_t FIELD_LAST         = 6'd36;

	localparam logic [7:0] BLEND_ONE_COLOR = 8'h10;
	localparam logic [7:0] CORNER_MASK     = 8'h0F;

	function automatic logic [2:0] field_size(field_id_t id);
		logic [2:0] size;
		case (id)
			6'd0, 6'd2, 6'd3, 6'd4, 6'd5, 6'd13, 6'd22,
			6'd31, 6'd32, 6'd33, 6'd35, 6'd36: size = 3'd2;
			6'd27, 6'd28: size = 3'd1;
			default: size = 3'd4;
		endcase
		return size;
	endfunction

	function automatic field_vec_t field_present(logic [30:0] flags, logic [7:0] sub);
		field_vec_t p;
		p[0]     = 1'b1;
		p[1]     = 1'b1;
		p[5:2]   = flags[6:3];
		p[12:6]  = flags[13:7];
		p[13]    = flags[14];
		p[21:14] = flags[24:17];
		p[22]    = flags[16];
		p[26:23] = sub[3:0] & {4{flags[16]}};
		p[27]    = flags[15];
		p[28]    = flags[15];
		p[29]    = flags[15] & sub[4];
		p[30]    = flags[15] & sub[4];
		p[36:31] = flags[30:25];
		return p;
	endfunction

endpackage

FILE: rtl/core/fppr_in_if.sv
interface fppr_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       frame_start;

	modport source (output valid, data_byte, frame_start, input ready);
	modport sink (input valid, data_byte, frame_start, output ready);
endinterface

FILE: rtl/core/fppr_out_if.sv
interface fppr_out_if;
	logic                  valid;
	logic                  ready;
	fppr_pkg::field_id_t   field_id;
	logic [31:0]           field_value;
	logic [7:0]            part_number;
	logic                  part_done;
	logic                  frame_done;
	logic                  unsupported_error;

	modport source (output valid, field_id, field_value, part_number, part_done,
		frame_done, unsupported_error, input ready);
	modport sink (input valid, field_id, field_value, part_number, part_done,
		frame_done, unsupported_error, output ready);
endinterface

FILE: rtl/core/flagged_part_record_parser_unit.sv
// Frame part-record parser: takes one byte per beat of a frame's little-endian
// part records and returns one beat per completed field (index, flags word, then
// each present optional field), tagged with the record position and end marks.
// Throughput is one byte per cycle unless the field output stalls; a field's beat
// leaves after its last byte is accepted, through the input register, then the
// result register. The field cursor, the byte counter and the next-present-field
// priority encoder all step once per accepted byte, which sets that rate. A blend
// flag byte that asks for per-corner colors yields an error beat and the block
// drops bytes until the next frame_start, as it does once parts_per_frame records
// (at most 256) are done. Write parts_per_frame only while no beat is in flight.
module flagged_part_record_parser_unit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  fppr_pkg::part_count_t cfg_wr_data,
	fppr_in_if.sink               byte_stream,
	fppr_out_if.source            field_stream
);
	import fppr_pkg::*;

	part_count_t ppf_q;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        start_s1;

	logic [30:0] flags_q;
	logic [7:0]  sub_q;
	field_id_t   cursor_q;
	logic [1:0]  bif_q;
	logic [31:0] acc_q;
	part_count_t counter_q;
	logic        halted_q;

	logic        out_valid_q;
	field_id_t   id_q;
	logic [31:0] value_q;
	logic [7:0]  part_q;
	logic        pdone_q;
	logic        fdone_q;
	logic        err_q;

	logic        advance;
	logic        take_s1;
	logic [30:0] flags_b, flags_n, flags_d;
	logic [7:0]  sub_b, sub_n, sub_d;
	field_id_t   cursor_b, cursor_d, id, next_id;
	logic [1:0]  bif_b, bif_d;
	logic [31:0] acc_b, acc_new, acc_d;
	part_count_t counter_b, counter_inc, counter_d, count;
	logic        halted_b, halted_d;
	logic        active, complete, err, has_next, part_done, frame_done;
	logic [2:0]  bif_inc;
	field_vec_t  present, cand;

	assign advance = !out_valid_q || field_stream.ready;
	assign take_s1 = valid_s1 && advance;
	assign byte_stream.ready = !valid_s1 || advance;

	always_comb begin
		flags_b   = start_s1 ? '0 : flags_q;
		sub_b     = start_s1 ? '0 : sub_q;
		cursor_b  = start_s1 ? FIELD_INDEX : cursor_q;
		bif_b     = start_s1 ? '0 : bif_q;
		acc_b     = start_s1 ? '0 : acc_q;
		counter_b = start_s1 ? '0 : counter_q;
		halted_b  = start_s1 ? 1'b0 : halted_q;

		count  = (ppf_q > MAX_PARTS) ? MAX_PARTS : ppf_q;
		active = !halted_b && (counter_b < count);
		id     = (cursor_b > FIELD_LAST) ? FIELD_INDEX : cursor_b;

		acc_new  = acc_b | ({24'b0, byte_s1} << {bif_b, 3'b000});
		bif_inc  = {1'b0, bif_b} + 3'd1;
		complete = active && (bif_inc >= field_size(id));

		flags_n = (id == FIELD_FLAGS) ? acc_new[30:0] : flags_b;
		sub_n   = (id == FIELD_VERTEX_FLAGS || id == FIELD_BLEND_FLAGS) ? acc_new[7:0] : sub_b;
		err     = (id == FIELD_BLEND_FLAGS) && ((sub_n & BLEND_ONE_COLOR) == '0)
			&& ((sub_n & CORNER_MASK) != '0);

		present = field_present(flags_n, sub_n);
		for (int i = 0; i < NumFields; i++) begin
			cand[i] = present[i] && (6'(i) > id);
		end
		has_next = |cand;
		next_id  = FIELD_INDEX;
		for (int i = NumFields - 1; i >= 0; i--) begin
			if (cand[i]) begin
				next_id = 6'(i);
			end
		end

		counter_inc = counter_b + 9'd1;
		part_done   = complete && !err && !has_next;
		frame_done  = part_done && (counter_inc >= count);

		flags_d   = flags_b;
		sub_d     = sub_b;
		cursor_d  = cursor_b;
		bif_d     = bif_b;
		acc_d     = acc_b;
		counter_d = counter_b;
		halted_d  = halted_b;
		if (active && !complete) begin
			acc_d = acc_new;
			bif_d = bif_inc[1:0];
		end else if (complete) begin
			acc_d   = '0;
			bif_d   = '0;
			flags_d = flags_n;
			sub_d   = sub_n;
			if (err) begin
				halted_d = 1'b1;
			end else if (has_next) begin
				cursor_d = next_id;
			end else begin
				counter_d = counter_inc;
				flags_d   = '0;
				sub_d     = '0;
				cursor_d  = FIELD_INDEX;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppf_q <= '0;
		end else if (cfg_wr_en) begin
			ppf_q <= cfg_wr_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_stream.ready) begin
			valid_s1 <= byte_stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_stream.valid && byte_stream.ready) begin
			byte_s1  <= byte_stream.data_byte;
			start_s1 <= byte_stream.frame_start;
		end
	end

	// parse state, advanced once per byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q   <= '0;
			sub_q     <= '0;
			cursor_q  <= FIELD_INDEX;
			bif_q     <= '0;
			acc_q     <= '0;
			counter_q <= '0;
			halted_q  <= 1'b0;
		end else if (take_s1) begin
			flags_q   <= flags_d;
			sub_q     <= sub_d;
			cursor_q  <= cursor_d;
			bif_q     <= bif_d;
			acc_q     <= acc_d;
			counter_q <= counter_d;
			halted_q  <= halted_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= take_s1 && complete;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1 && complete) begin
			id_q    <= id;
			value_q <= acc_new;
			part_q  <= counter_b[7:0];
			pdone_q <= part_done;
			fdone_q <= frame_done;
			err_q   <= err;
		end
	end

	assign field_stream.valid             = out_valid_q;
	assign field_stream.field_id          = id_q;
	assign field_stream.field_value       = value_q;
	assign field_stream.part_number       = part_q;
	assign field_stream.part_done         = pdone_q;
	assign field_stream.frame_done        = fdone_q;
	assign field_stream.unsupported_error = err_q;

endmodule

FILE: rtl/core/fppr_checker.sv
module fppr_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_ready,
	input fppr_pkg::field_id_t field_id,
	input logic [31:0]         field_value,
	input logic [7:0]          part_number,
	input logic                part_done,
	input logic                frame_done,
	input logic                unsupported_error
);
	import fppr_pkg::*;

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(field_id)
			&& $stable(field_value) && $stable(part_number) && $stable(part_done)
			&& $stable(frame_done) && $stable(unsupported_error))
		else $error("result beat changed while stalled");

	a_error_beat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && unsupported_error |->
			field_id == FIELD_BLEND_FLAGS && !part_done && !frame_done)
		else $error("error beat not on blend flag field or marked as record end");

	a_frame_in_part: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_done |-> part_done)
		else $error("frame end without record end");

	a_record_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && part_done |-> field_id != FIELD_INDEX)
		else $error("record ended on its index field");

endmodule

bind flagged_part_record_parser_unit fppr_checker u_fppr_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.out_valid         (field_stream.valid),
	.out_ready         (field_stream.ready),
	.field_id          (field_stream.field_id),
	.field_value       (field_stream.field_value),
	.part_number       (field_stream.part_number),
	.part_done         (field_stream.part_done),
	.frame_done        (field_stream.frame_done),
	.unsupported_error (field_stream.unsupported_error)
);

FILE: sim/flagged_part_record_parser_unit_tb.sv
`timescale 1ns / 100ps

module flagged_part_record_parser_unit_tb;
	import fppr_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int RANDOM_BYTES = 160;
	localparam int SETTLE_CYCLES = 8;
	localparam int LONG_HOLD = 400;
	localparam int HOLD_AFTER_BEATS = 60;
	localparam logic [36:0] TWO_BYTE_FIELDS = 37'h1B_8040_203D;
	localparam logic [36:0] ONE_BYTE_FIELDS = 37'h00_1800_0000;

	typedef struct packed {
		logic [7:0] data;
		logic       first;
	} pending_byte_t;

	typedef struct packed {
		field_id_t   id;
		logic [31:0] value;
		logic [7:0]  part;
		logic        last_of_part;
		logic        last_of_frame;
		logic        unsupported;
	} field_beat_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	part_count_t cfg_wr_data;

	fppr_in_if bytes_bus ();
	fppr_out_if fields_bus ();

	flagged_part_record_parser_unit uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.byte_stream (bytes_bus),
		.field_stream(fields_bus)
	);

	pending_byte_t byte_queue[$];
	field_beat_t field_expect_q[$];

	part_count_t cfg_parts;
	logic [30:0] rec_flags;
	logic [7:0] rec_sub;
	field_id_t rec_cursor;
	int rec_byte_cnt;
	logic [31:0] rec_acc;
	part_count_t parts_done;
	logic halted;

	int errors;
	int cycles;
	int bytes_fed;
	int send_gap;
	int recv_gap;
	int hold_left;
	int beats_seen;
	logic held_once;
	logic calm;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int field_bytes(int id);
		if (ONE_BYTE_FIELDS[id])
			return 1;
		if (TWO_BYTE_FIELDS[id])
			return 2;
		return 4;
	endfunction

	function automatic logic has_field(logic [30:0] f, logic [7:0] s, int id);
		if (id <= FIELD_FLAGS)
			return 1'b1;
		if (id <= 13)
			return f[id + 1];
		if (id <= 21)
			return f[id + 3];
		if (id == FIELD_VERTEX_FLAGS)
			return f[16];
		if (id <= 26)
			return f[16] & s[id - 23];
		if (id <= FIELD_BLEND_FLAGS)
			return f[15];
		if (id <= 30)
			return f[15] && ((s & BLEND_ONE_COLOR) != 0);
		return f[id - 6];
	endfunction

	function automatic logic blend_unsupported(logic [7:0] s);
		return ((s & BLEND_ONE_COLOR) == 0) && ((s & CORNER_MASK) != 0);
	endfunction

	task automatic drop_record();
		rec_flags = '0;
		rec_sub = '0;
		rec_cursor = FIELD_INDEX;
		rec_byte_cnt = 0;
		rec_acc = '0;
	endtask

	task automatic parse_byte(input logic [7:0] b, input logic first);
		part_count_t lim;
		int id;
		int nxt;
		logic [31:0] val;
		logic err;
		field_beat_t beat;
		if (first) begin
			parts_done = '0;
			halted = 1'b0;
			drop_record();
		end
		lim = (cfg_parts > MAX_PARTS) ? MAX_PARTS : cfg_parts;
		if (halted || parts_done >= lim)
			return;
		id = rec_cursor;
		rec_acc = rec_acc | (32'(b) << (8 * rec_byte_cnt));
		rec_byte_cnt = rec_byte_cnt + 1;
		if (rec_byte_cnt < field_bytes(id))
			return;
		val = rec_acc;
		rec_acc = '0;
		rec_byte_cnt = 0;
		if (id == FIELD_FLAGS)
			rec_flags = val[30:0];
		if (id == FIELD_VERTEX_FLAGS || id == FIELD_BLEND_FLAGS)
			rec_sub = val[7:0];
		err = (id == FIELD_BLEND_FLAGS) && blend_unsupported(rec_sub);
		beat.id = field_id_t'(id);
		beat.value = val;
		beat.part = parts_done[7:0];
		beat.last_of_part = 1'b0;
		beat.last_of_frame = 1'b0;
		beat.unsupported = err;
		if (err) begin
			halted = 1'b1;
		end else begin
			nxt = id + 1;
			while (nxt <= FIELD_LAST && !has_field(rec_flags, rec_sub, nxt))
				nxt++;
			if (nxt > FIELD_LAST) begin
				beat.last_of_part = 1'b1;
				parts_done = parts_done + 1'b1;
				drop_record();
				beat.last_of_frame = parts_done >= lim;
			end else begin
				rec_cursor = field_id_t'(nxt);
			end
		end
		field_expect_q = {field_expect_q, beat};
	endtask

	task automatic push_byte(input logic [7:0] b, input logic first);
		pending_byte_t pb;
		pb.data = b;
		pb.first = first;
		byte_queue = {byte_queue, pb};
		bytes_fed++;
	endtask

	task automatic push_record(input logic [15:0] idx, input logic [31:0] fw,
			input logic [7:0] vf, input logic [7:0] bf, input logic first, input int budget);
		logic [31:0] v;
		logic [7:0] s;
		int sent;
		sent = 0;
		for (int id = 0; id <= FIELD_LAST; id++) begin
			s = (id >= FIELD_BLEND_FLAGS) ? bf : vf;
			if (has_field(fw[30:0], s, id)) begin
				v = $urandom;
				if (id == FIELD_INDEX)
					v = {16'h0000, idx};
				else if (id == FIELD_FLAGS)
					v = fw;
				else if (id == FIELD_VERTEX_FLAGS)
					v[7:0] = vf;
				else if (id == FIELD_BLEND_FLAGS)
					v[7:0] = bf;
				for (int n = 0; n < field_bytes(id); n++) begin
					if (sent == budget)
						return;
					push_byte(v[8 * n +: 8], first && sent == 0);
					sent++;
				end
				if (id == FIELD_BLEND_FLAGS && blend_unsupported(bf))
					return;
			end
		end
	endtask

	function automatic logic [31:0] rand_flags();
		logic [31:0] f;
		case ($urandom_range(0, 9))
			0: f = 32'hFFFF_FFFF;
			1: f = $urandom;
			2: f = {1'($urandom), 31'h0};
			default: begin
				f = $urandom & $urandom & $urandom;
				f[15] = f[15] | ($urandom_range(0, 2) == 0);
				f[16] = f[16] | ($urandom_range(0, 3) == 0);
			end
		endcase
		return f;
	endfunction

	function automatic logic [7:0] rand_blend();
		logic [7:0] r;
		r = 8'($urandom);
		case ($urandom_range(0, 5))
			0: begin
				r = r & ~BLEND_ONE_COLOR;
				r[3:0] = 4'($urandom_range(1, 15));
			end
			1: r[4:0] = 5'h00;
			default: r = r | BLEND_ONE_COLOR;
		endcase
		return r;
	endfunction

	task automatic push_frame(input int recs, input logic cut);
		int total;
		total = (recs > 0) ? recs : 1;
		for (int r = 0; r < total; r++)
			push_record(16'($urandom), rand_flags(), 8'($urandom), rand_blend(), r == 0,
				(cut && r == total - 1) ? $urandom_range(1, 12) : 4096);
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 4)) push_byte(8'($urandom), 1'b0);
	endtask

	task automatic settle();
		while (byte_queue.size() != 0 || bytes_bus.valid || field_expect_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_parts(input part_count_t n);
		settle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= n;
		@(posedge clk);
		cfg_parts = n;
		cfg_wr_en <= 1'b0;
	endtask

	always @(posedge clk or negedge arst_n) begin : drive_bytes
		pending_byte_t nb;
		if (!arst_n) begin
			bytes_bus.valid <= 1'b0;
			bytes_bus.data_byte <= '0;
			bytes_bus.frame_start <= 1'b0;
			send_gap = 0;
		end else begin
			if (bytes_bus.valid && bytes_bus.ready)
				parse_byte(bytes_bus.data_byte, bytes_bus.frame_start);
			if (!bytes_bus.valid || bytes_bus.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					bytes_bus.valid <= 1'b0;
				end else if (!calm && $urandom_range(0, 15) == 0) begin
					send_gap = $urandom_range(0, 10);
					bytes_bus.valid <= 1'b0;
				end else if (byte_queue.size() != 0) begin
					nb = byte_queue.pop_front();
					bytes_bus.valid <= 1'b1;
					bytes_bus.data_byte <= nb.data;
					bytes_bus.frame_start <= nb.first;
				end else begin
					bytes_bus.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : watch_fields
		field_beat_t want;
		field_beat_t got;
		if (!arst_n) begin
			fields_bus.ready <= 1'b0;
			recv_gap = 0;
			hold_left = 0;
		end else begin
			if (fields_bus.valid && fields_bus.ready) begin
				got.id = fields_bus.field_id;
				got.value = fields_bus.field_value;
				got.part = fields_bus.part_number;
				got.last_of_part = fields_bus.part_done;
				got.last_of_frame = fields_bus.frame_done;
				got.unsupported = fields_bus.unsupported_error;
				if (field_expect_q.size() == 0) begin
					errors++;
					$display("%0t unexpected beat: id=%0d value=%h part=%0d pd=%b fd=%b err=%b",
						$time, got.id, got.value, got.part, got.last_of_part,
						got.last_of_frame, got.unsupported);
				end else begin
					want = field_expect_q.pop_front();
					if (got !== want) begin
						errors++;
						$display("%0t mismatch: expected id=%0d value=%h part=%0d pd=%b fd=%b err=%b",
							$time, want.id, want.value, want.part, want.last_of_part,
							want.last_of_frame, want.unsupported);
						$display("%0t          actual   id=%0d value=%h part=%0d pd=%b fd=%b err=%b",
							$time, got.id, got.value, got.part, got.last_of_part,
							got.last_of_frame, got.unsupported);
					end
				end
				beats_seen++;
				if (!held_once && beats_seen == HOLD_AFTER_BEATS) begin
					held_once = 1'b1;
					hold_left = LONG_HOLD;
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				fields_bus.ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				fields_bus.ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 15) == 0) begin
				recv_gap = $urandom_range(0, 10);
				fields_bus.ready <= 1'b0;
			end else begin
				fields_bus.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("flagged_part_record_parser_unit_tb NOT OK");
			$finish;
		end
	end

	initial begin
		int goal;
		part_count_t n;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		bytes_bus.valid = 1'b0;
		bytes_bus.data_byte = '0;
		bytes_bus.frame_start = 1'b0;
		fields_bus.ready = 1'b0;
		errors = 0;
		cycles = 0;
		bytes_fed = 0;
		beats_seen = 0;
		held_once = 1'b0;
		calm = 1'b0;
		cfg_parts = '0;
		parts_done = '0;
		halted = 1'b0;
		drop_record();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// count of zero: drop everything
		push_byte(8'hFF, 1'b0);
		push_byte(8'h00, 1'b1);
		set_parts(9'd1);
		// no frame_start after reset, flag bit 31 alone adds nothing
		push_record(16'hFFFF, 32'h8000_0000, 8'h00, 8'h00, 1'b0, 4096);
		push_byte(8'hA5, 1'b0);
		push_record(16'h0000, 32'h0000_8000, 8'h00, 8'h0F, 1'b1, 4096);
		push_byte(8'h5A, 1'b0);
		push_record(16'h1234, 32'h0001_8000, 8'h0F, 8'h10, 1'b1, 3);
		push_record(16'h8001, 32'h0000_8000, 8'h00, 8'hFF, 1'b1, 4096);
		set_parts(9'd2);
		push_record(16'h00FF, 32'h7FFF_FFFF, 8'hFF, 8'h1F, 1'b1, 4096);
		push_record(16'hFF00, 32'h0001_0000, 8'h05, 8'h00, 1'b0, 4096);

		goal = bytes_fed + RANDOM_BYTES;
		while (bytes_fed < goal) begin
			case ($urandom_range(0, 6))
				0: n = 9'd0;
				1: n = 9'd1;
				default: n = part_count_t'($urandom_range(2, 5));
			endcase
			set_parts(n);
			repeat (2) begin
				case ($urandom_range(0, 9))
					0: repeat ($urandom_range(1, 12))
						push_byte(8'($urandom), $urandom_range(0, 3) == 0);
					1: push_frame(n, 1'b1);
					default: push_frame(n, 1'b0);
				endcase
			end
		end

		calm = 1'b1;
		set_parts(MAX_PARTS);
		push_frame(2, 1'b1);

		set_parts(9'd511);
		for (int r = 0; r < 4; r++)
			push_record(16'($urandom), {1'($urandom), 31'h0}, 8'h00, 8'h00, r == 0, 4096);
		push_byte(8'($urandom), 1'b0);

		settle();
		if (errors == 0 && field_expect_q.size() == 0)
			$display("flagged_part_record_parser_unit_tb OK");
		else
			$display("flagged_part_record_parser_unit_tb NOT OK");
		$finish;
	end

endmodule
